FILE: sv/assert_macros.svh
// Assertion helpers used by the stream_find_replace top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on the rising clock edge, masked during reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/sfr_pkg.sv
package sfr_pkg;

  localparam int PATTERN_MAX     = 16;
  localparam int REPLACEMENT_MAX = 16;
  localparam int WIN_BYTES       = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN  = 3'd0,
    REG_PAT_LO   = 3'd1,
    REG_PAT_HI   = 3'd2,
    REG_REP_LEN  = 3'd3,
    REG_REP_LO   = 3'd4,
    REG_REP_HI   = 3'd5,
    REG_REP_EVRY = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]                     pat_len;
    logic [PATTERN_MAX-1:0][7:0]    pat;
    logic [4:0]                     rep_len;
    logic [REPLACEMENT_MAX-1:0][7:0] rep;
    logic                           every;
  } cfg_t;

  // One command from the front: emit the first cnt words of bytes
  typedef struct packed {
    logic [WIN_BYTES-1:0][7:0] bytes;
    logic [4:0]                cnt;
    logic                      last;
    logic [15:0]               tally;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: sv/sfr_in_if.sv
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, data_byte, byte_present, end_of_text, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_text, output ready);
endinterface

FILE: sv/sfr_out_if.sv
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_present;
  logic        out_last;
  logic [15:0] replacement_count;

  modport source (output valid, out_byte, out_present, out_last, replacement_count,
                  input ready);
  modport sink   (input valid, out_byte, out_present, out_last, replacement_count,
                  output ready);
endinterface

FILE: sv/sfr_front.sv
module sfr_front
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  fifo_stat_t stat_i,
  sfr_in_if.sink     in_if,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [WIN_BYTES-1:0][7:0] win_q, win_d, lst;
  logic [3:0]  fill_q, fill_d;
  logic        first_q, first_d;
  logic [15:0] tally_q, tally_d, tally_hit;
  logic [4:0]  plen, rlen, len, k;
  logic        accept, p, e, mis, hit;

  assign in_if.ready = !stat_i.full;
  assign accept      = in_if.valid && in_if.ready;
  assign p           = in_if.byte_present;
  assign e           = in_if.end_of_text;

  // Clamp the lengths
  assign plen = (cfg_i.pat_len > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : cfg_i.pat_len;
  assign rlen = (cfg_i.rep_len > 5'(REPLACEMENT_MAX)) ? 5'(REPLACEMENT_MAX) : cfg_i.rep_len;
  assign len  = {1'b0, fill_q} + 5'(p);

  // Window with the new byte appended after the held ones
  always_comb begin
    lst = win_q;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (5'(i) >= {1'b0, fill_q}) lst[i] = in_if.data_byte;
    end
  end

  // Whole-window compare against the pattern
  always_comb begin
    mis = 1'b0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (5'(i) < plen && lst[i] != cfg_i.pat[i]) mis = 1'b1;
    end
  end

  assign hit = p && (plen != 5'd0) && ({1'b0, fill_q} < plen) && (len == plen) &&
               (cfg_i.every || !first_q) && !mis;

  // Number of oldest words leaving the window when there is no hit
  always_comb begin
    priority if (e)                       k = len;
    else if (!p)                          k = 5'd0;
    else if (plen == 5'd0)                k = len;
    else if ({1'b0, fill_q} >= plen)      k = len - plen + 5'd1;
    else if (len == plen)                 k = 5'd1;
    else                                  k = 5'd0;
  end

  // Shift the window left by k
  always_comb begin
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      idx = 5'(i) + k;
      win_d[i] = (idx < 5'(WIN_BYTES)) ? lst[idx[3:0]] : 8'h00;
    end
  end

  assign tally_hit = (hit && tally_q != 16'hFFFF) ? tally_q + 16'd1 : tally_q;
  assign fill_d    = (e || hit) ? 4'd0 : 4'(len - k);
  assign first_d   = e ? 1'b0 : (first_q || hit);
  assign tally_d   = e ? 16'd0 : tally_hit;

  // Command for the back end
  always_comb begin
    cmd_o.bytes = hit ? cfg_i.rep : lst;
    cmd_o.cnt   = hit ? rlen : k;
    cmd_o.last  = e;
    cmd_o.tally = tally_hit;
  end

  assign push_o = accept && ((cmd_o.cnt != 5'd0) || e);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      first_q <= 1'b0;
      tally_q <= '0;
    end else if (accept) begin
      fill_q  <= fill_d;
      first_q <= first_d;
      tally_q <= tally_d;
    end
  end

  // Window bytes
  always_ff @(posedge clk_i) begin
    if (accept) win_q <= win_d;
  end

endmodule

FILE: sv/sfr_cmd_fifo.sv
module sfr_cmd_fifo
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmd_t       head_o,
  output fifo_stat_t stat_o
);

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= cmd_i;
  end

endmodule

FILE: sv/sfr_back.sv
module sfr_back
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  sfr_out_if.source  out_if
);

  logic [3:0]  idx_q, idx_d;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        present_q, last_q;
  logic [15:0] count_q;
  logic        load, final_word;

  assign load       = !stat_i.empty && (!valid_q || out_if.ready);
  assign final_word = (head_i.cnt == 5'd0) || (({1'b0, idx_q} + 5'd1) == head_i.cnt);
  assign pop_o      = load && final_word;
  assign idx_d      = final_word ? 4'd0 : idx_q + 4'd1;

  // Word index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= idx_d;
      if (load)              valid_q <= 1'b1;
      else if (out_if.ready) valid_q <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= (head_i.cnt == 5'd0) ? 8'h00 : head_i.bytes[idx_q];
      present_q <= (head_i.cnt != 5'd0);
      last_q    <= head_i.last && final_word;
      count_q   <= (head_i.last && final_word) ? head_i.tally : 16'd0;
    end
  end

  assign out_if.valid             = valid_q;
  assign out_if.out_byte          = byte_q;
  assign out_if.out_present       = present_q;
  assign out_if.out_last          = last_q;
  assign out_if.replacement_count = count_q;

endmodule

FILE: sv/stream_find_replace.sv
// Streaming find-and-replace over a byte stream.
// Input channel in_if carries one word per item: a text byte, a flag telling
// whether the byte is real, and an end-of-text flag that flushes the window.
// Output channel out_if carries rewritten bytes; the word marked out_last
// closes the text and carries the saturating replacement count.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.
// Throughput: one input word per cycle. The front end updates the window and
// compares it against the pattern in the cycle the word is accepted, then
// queues a command; the back end expands each command at one output word per
// cycle while the receiver is ready. The input stalls only when the 4-entry
// command queue is full. With the queue empty, the first result word of an
// item goes through the command queue, then the output register, to out_if.
// A stalled receiver holds the output register; the queue keeps taking input
// until it fills. Reset empties the window and queue, clears the tally and
// restores the configuration defaults (replace every occurrence, no pattern).
module stream_find_replace
  import sfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sfr_in_if.sink                in_if,
  sfr_out_if.source             out_if
);

`include "assert_macros.svh"

  cfg_t       cfg_q;
  cmd_t       cmd, head;
  fifo_stat_t stat;
  logic       push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pat_len: '0, pat: '0, rep_len: '0, rep: '0, every: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAT_LEN:  cfg_q.pat_len   <= cfg_wdata_i[4:0];
        REG_PAT_LO:   cfg_q.pat[7:0]  <= cfg_wdata_i;
        REG_PAT_HI:   cfg_q.pat[15:8] <= cfg_wdata_i;
        REG_REP_LEN:  cfg_q.rep_len   <= cfg_wdata_i[4:0];
        REG_REP_LO:   cfg_q.rep[7:0]  <= cfg_wdata_i;
        REG_REP_HI:   cfg_q.rep[15:8] <= cfg_wdata_i;
        REG_REP_EVRY: cfg_q.every     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .stat_i (stat),
    .in_if  (in_if),
    .push_o (push),
    .cmd_o  (cmd)
  );

  sfr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  sfr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_if (out_if)
  );

  // Checks
  `SFR_ASSERT_IMP(a_count_only_last, out_if.valid && !out_if.out_last, out_if.replacement_count == 16'd0, "count on a non-final word")
  `SFR_ASSERT_IMP(a_empty_is_last, out_if.valid && !out_if.out_present, out_if.out_last, "empty word that is not final")
  `SFR_ASSERT_IMP(a_no_push_full, stat.full, !push, "command pushed into a full queue")

endmodule

FILE: verif/stream_find_replace_tb.sv
module stream_find_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int unsigned MAX_CYCLES    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_WORDS  = 140;
  localparam int unsigned TALLY_MATCHES = 30;

  // One rewritten word as seen on the output channel
  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic [15:0] count;
  } out_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stream_find_replace dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic [4:0]  cfg_pat_len = 5'd0;
  logic [63:0] cfg_pat_lo  = '0;
  logic [63:0] cfg_pat_hi  = '0;
  logic [4:0]  cfg_rep_len = 5'd0;
  logic [63:0] cfg_rep_lo  = '0;
  logic [63:0] cfg_rep_hi  = '0;
  logic        cfg_every   = 1'b1;

  // Shadow copy of the matching window and per-text state
  logic [7:0]  win_bytes [WIN_BYTES];
  int unsigned win_fill   = 0;
  bit          first_done = 1'b0;
  logic [15:0] tally      = '0;

  out_word_t   step_q[$];
  out_word_t   rewritten_q[$];

  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  bit          gaps_on        = 1'b0;
  bit          stalls_on      = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served  = 0;

  function automatic logic [7:0] lane(input logic [63:0] lo, input logic [63:0] hi,
                                      input int unsigned i);
    logic [63:0] w;
    w = (i < 8) ? lo : hi;
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned pattern_len_eff();
    return (cfg_pat_len > PATTERN_MAX) ? PATTERN_MAX : cfg_pat_len;
  endfunction

  function automatic void emit_word(input logic [7:0] b, input logic present);
    out_word_t w;
    w = '0;
    w.data    = b;
    w.present = present;
    step_q.push_back(w);
  endfunction

  // Oldest window byte goes out, the rest shift down
  function automatic void release_oldest();
    if (win_fill == 0) return;
    emit_word(win_bytes[0], 1'b1);
    for (int i = 0; i < WIN_BYTES - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_fill--;
  endfunction

  // Work out the words caused by one accepted input word
  task automatic predict_rewrite(input logic [7:0] b, input logic present, input logic eot);
    int unsigned plen;
    int unsigned rlen;
    bit          hit;
    out_word_t   w;
    plen = pattern_len_eff();
    rlen = (cfg_rep_len > REPLACEMENT_MAX) ? REPLACEMENT_MAX : cfg_rep_len;
    if (present) begin
      if (plen == 0) begin
        // replacement off: flush anything left, then pass the byte
        while (win_fill > 0) release_oldest();
        emit_word(b, 1'b1);
      end else if (win_fill >= plen) begin
        // pattern got shorter mid-text: trim, add, drop one more, no compare
        while (win_fill >= plen) release_oldest();
        win_bytes[win_fill] = b;
        win_fill++;
        release_oldest();
      end else begin
        win_bytes[win_fill] = b;
        win_fill++;
        if (win_fill == plen) begin
          hit = cfg_every || !first_done;
          for (int i = 0; i < plen; i++)
            if (win_bytes[i] != lane(cfg_pat_lo, cfg_pat_hi, i)) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) emit_word(lane(cfg_rep_lo, cfg_rep_hi, i), 1'b1);
            win_fill   = 0;
            first_done = 1'b1;
            if (tally != 16'hFFFF) tally++;
          end else begin
            release_oldest();
          end
        end
      end
    end
    if (eot) begin
      while (win_fill > 0) release_oldest();
      // nothing left to send: an empty closing word carries the count
      if (step_q.size() == 0) emit_word(8'h00, 1'b0);
      w = step_q.pop_back();
      w.last  = 1'b1;
      w.count = tally;
      step_q.push_back(w);
      win_fill   = 0;
      first_done = 1'b0;
      tally      = '0;
    end
    while (step_q.size() != 0) rewritten_q.push_back(step_q.pop_front());
  endtask

  // Offer one input word, wait for acceptance, then predict
  task automatic send_word(input logic [7:0] b, input logic present, input logic eot);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.byte_present <= present;
    in_ch.end_of_text  <= eot;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_rewrite(b, present, eot);
  endtask

  // Stop offering and wait until the block has gone quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PAT_LEN:  cfg_pat_len = val[4:0];
      REG_PAT_LO:   cfg_pat_lo  = val;
      REG_PAT_HI:   cfg_pat_hi  = val;
      REG_REP_LEN:  cfg_rep_len = val[4:0];
      REG_REP_LO:   cfg_rep_lo  = val;
      REG_REP_HI:   cfg_rep_hi  = val;
      REG_REP_EVRY: cfg_every   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [4:0] plen, input logic [63:0] pat_lo,
                              input logic [63:0] pat_hi, input logic [4:0] rlen,
                              input logic [63:0] rep_lo, input logic [63:0] rep_hi,
                              input logic every);
    settle_block();
    cfg_write(REG_PAT_LEN, {59'd0, plen});
    cfg_write(REG_PAT_LO, pat_lo);
    cfg_write(REG_PAT_HI, pat_hi);
    cfg_write(REG_REP_LEN, {59'd0, rlen});
    cfg_write(REG_REP_LO, rep_lo);
    cfg_write(REG_REP_HI, rep_hi);
    cfg_write(REG_REP_EVRY, {63'd0, every});
  endtask

  task automatic random_config();
    logic [4:0]  plen;
    logic [4:0]  rlen;
    logic [63:0] lo;
    logic [63:0] hi;
    case ($urandom_range(0, 9))
      0:       plen = 5'd0;
      1:       plen = 5'd16;
      2:       plen = 5'($urandom_range(17, 31));
      default: plen = 5'($urandom_range(1, 5));
    endcase
    case ($urandom_range(0, 9))
      0:       rlen = 5'd0;
      1:       rlen = 5'd16;
      2:       rlen = 5'($urandom_range(17, 31));
      default: rlen = 5'($urandom_range(0, 6));
    endcase
    // two-letter patterns give self-overlapping cases
    if ($urandom_range(0, 1)) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) begin
        lo[i * 8 +: 8] = 8'h61 + 8'($urandom_range(0, 1));
        hi[i * 8 +: 8] = 8'h61 + 8'($urandom_range(0, 1));
      end
    end
    apply_config(plen, lo, hi, rlen, {$urandom, $urandom}, {$urandom, $urandom},
                 1'($urandom_range(0, 1)));
  endtask

  // Random text seeded with whole, cut and spoiled copies of the pattern
  task automatic send_text(input int unsigned n_words, input bit close,
                           output int unsigned n_real);
    int unsigned plen;
    int unsigned cut;
    int unsigned bad;
    logic [7:0]  b;
    n_real = 0;
    plen   = pattern_len_eff();
    while (n_real < n_words) begin
      case ($urandom_range(0, 19))
        0: send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        1, 2, 3, 4, 5, 6, 7: begin
          cut = plen;
          bad = plen;
          if ($urandom_range(0, 2) == 0) cut = $urandom_range(0, plen);
          else if (plen != 0 && $urandom_range(0, 2) == 0) bad = $urandom_range(0, plen - 1);
          for (int k = 0; k < cut; k++) begin
            b = lane(cfg_pat_lo, cfg_pat_hi, k);
            if (k == bad) b = b ^ (8'h01 << $urandom_range(0, 7));
            send_word(b, 1'b1, 1'b0);
            n_real++;
          end
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       b = 8'($urandom_range(0, 255));
            1:       b = (plen == 0) ? 8'h61 : lane(cfg_pat_lo, cfg_pat_hi,
                                                    $urandom_range(0, plen - 1));
            default: b = 8'h61 + 8'($urandom_range(0, 1));
          endcase
          send_word(b, 1'b1, 1'b0);
          n_real++;
        end
      endcase
    end
    if (close) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Out of reset replacement is off: bytes pass, idle words vanish
  task automatic test_passthrough();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
  endtask

  // Leftmost matching, back-to-back matches, empty end with nothing left
  task automatic test_find_replace();
    logic [7:0] text [7];
    text = '{8'h61, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
    apply_config(5'd3, 64'h0000_0000_0063_6261, 64'd0, 5'd2, 64'h0000_0000_0000_5958,
                 64'd0, 1'b1);
    foreach (text[i]) send_word(text[i], 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  // Oversized lengths clip to 16, first-only mode, then shrink and disable mid-text
  task automatic test_lengths_mid_text();
    apply_config(5'd31, '1, '1, 5'd31, 64'h00FF_00FF_00FF_00FF, 64'h0123_4567_89AB_CDEF,
                 1'b0);
    repeat (16) send_word(8'hFF, 1'b1, 1'b0);
    repeat (3) send_word(8'hFF, 1'b1, 1'b0);
    settle_block();
    cfg_write(REG_PAT_LEN, 64'd2);
    send_word(8'h00, 1'b1, 1'b0);
    settle_block();
    cfg_write(REG_PAT_LEN, 64'd0);
    send_word(8'h01, 1'b1, 1'b1);
  endtask

  // Random settings, texts sometimes left open across a settings change
  task automatic test_random_texts();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      random_config();
      repeat ($urandom_range(1, 4)) begin
        send_text($urandom_range(1, 24), $urandom_range(0, 5) != 0, n);
        sent += n;
      end
    end
  endtask

  // Receiver holds off while expansions pile up in the command queue
  task automatic test_backpressure();
    int unsigned n;
    apply_config(5'd1, 64'h61, 64'd0, 5'd3, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    gaps_on = 1'b0;
    stall_requests++;
    send_text(40, 1'b1, n);
    gaps_on = 1'b1;
  endtask

  // Replacement count over a run of back-to-back matches that emit nothing
  task automatic test_tally_count();
    apply_config(5'd1, 64'h5A, 64'd0, 5'd0, 64'd0, 64'd0, 1'b1);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (TALLY_MATCHES) send_word(8'h5A, 1'b1, 1'b0);
    send_word(8'h5B, 1'b1, 1'b1);
  endtask

  // Full-rate streaming with no idling on either side
  task automatic test_full_rate();
    int unsigned n;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_config();
    send_text(25, 1'b1, n);
    random_config();
    send_text(25, 1'b1, n);
  endtask

  // Receiver ready: random stalls, plus the long hold when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted output word with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.data    = out_ch.out_byte;
      got.present = out_ch.out_present;
      got.last    = out_ch.out_last;
      got.count   = out_ch.replacement_count;
      if (rewritten_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: byte %h present %b last %b count %0d", $time,
                 got.data, got.present, got.last, got.count);
      end else begin
        want = rewritten_q.pop_front();
        if (got.data !== want.data || got.present !== want.present ||
            got.last !== want.last || got.count !== want.count) begin
          error_count++;
          $display("%0t: mismatch: expected byte %h present %b last %b count %0d, got byte %h present %b last %b count %0d",
                   $time, want.data, want.present, want.last, want.count,
                   got.data, got.present, got.last, got.count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("stream_find_replace verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_PAT_LEN;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.byte_present <= 1'b0;
    in_ch.end_of_text  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_passthrough();
    test_find_replace();
    test_lengths_mid_text();
    test_random_texts();
    test_backpressure();
    test_tally_count();
    test_full_rate();
    settle_block();

    if (error_count == 0) begin
      $display("stream_find_replace verification clean");
    end else begin
      $display("stream_find_replace verification failed");
    end
    $finish;
  end

endmodule
